### sv/ohlc_pkg.sv
package ohlc_pkg;

   localparam int EPOCH_W  = 32;
   localparam int PRICE_W  = 40;
   localparam int PERIOD_W = 17;
   localparam int GAP_W    = 31;
   localparam int CSR_W    = 32;

   localparam logic [PERIOD_W-1:0] CANDLE_SECONDS_RESET  = 17'd300;
   localparam logic [EPOCH_W-1:0]  VALID_EPOCH_MIN_RESET = 32'd1600000000;
   localparam logic [GAP_W-1:0]    GAP_MAX               = 31'h7FFF_FFFF;

   // Register indexes on the csr port
   localparam logic CSR_CANDLE_SECONDS  = 1'b0;
   localparam logic CSR_VALID_EPOCH_MIN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic                busy;
      logic [EPOCH_W-1:0]  quotient;
      logic [PERIOD_W-1:0] remainder;
   } div_status_type;

endpackage

### sv/ohlc_div.sv
module ohlc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ohlc_pkg::EPOCH_W-1:0]    dividend,
   input  logic [ohlc_pkg::PERIOD_W-1:0]   divisor,
   output ohlc_pkg::div_status_type        status
);

   localparam int CNT_W = $clog2(ohlc_pkg::EPOCH_W);

   logic                            busy_ff;
   logic [CNT_W-1:0]                count_ff;
   logic [ohlc_pkg::EPOCH_W-1:0]    dq_ff;
   logic [ohlc_pkg::PERIOD_W-1:0]   rem_ff;
   logic [ohlc_pkg::PERIOD_W-1:0]   divisor_ff;

   logic [ohlc_pkg::PERIOD_W:0]     trial;
   logic [ohlc_pkg::PERIOD_W+1:0]   diff;
   logic                            fits;

   // One quotient bit per cycle: shift in the next dividend bit, try a subtract
   assign trial = {rem_ff, dq_ff[ohlc_pkg::EPOCH_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor_ff};
   assign fits  = ~diff[ohlc_pkg::PERIOD_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && (count_ff == CNT_W'(ohlc_pkg::EPOCH_W - 1))) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff   <= '0;
         dq_ff      <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         count_ff <= count_ff + CNT_W'(1);
         dq_ff    <= {dq_ff[ohlc_pkg::EPOCH_W-2:0], fits};
         rem_ff   <= fits ? diff[ohlc_pkg::PERIOD_W-1:0] : trial[ohlc_pkg::PERIOD_W-1:0];
      end
   end

   assign status.busy      = busy_ff;
   assign status.quotient  = dq_ff;
   assign status.remainder = rem_ff;

endmodule

### sv/ohlc_candle_aggregator.sv
// An accepted request passes through the bit-serial bucket division, a step that
// sees the divider finish, an update and a step that forms the gap, in that order.
// The single-bit-per-cycle divider takes one request at a time: req_ready is high
// only while idle, and the update waits until the result register is free.
// Reset (synchronous, active high): period 300 s, epoch threshold 1600000000,
// no candle forming, no bucket closed, no result pending.
module ohlc_candle_aggregator (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ohlc_pkg::EPOCH_W-1:0]    req_now_epoch,
   input  logic [ohlc_pkg::PRICE_W-1:0]    req_price,
   input  logic                            req_price_valid,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_tick_accepted,
   output logic                            rsp_closed_valid,
   output logic [ohlc_pkg::EPOCH_W-1:0]    rsp_closed_start,
   output logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_open,
   output logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_high,
   output logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_low,
   output logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_last,
   output logic                            rsp_gap_flag,
   output logic [ohlc_pkg::GAP_W-1:0]      rsp_gap_count,

   input  logic                            csr_write_en,
   input  logic                            csr_index,
   input  logic [ohlc_pkg::CSR_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [ohlc_pkg::PERIOD_W-1:0]   candle_seconds_ff;
   logic [ohlc_pkg::EPOCH_W-1:0]    valid_epoch_min_ff;
   logic                            clear_candles;

   assign clear_candles = csr_write_en && (csr_index == ohlc_pkg::CSR_CANDLE_SECONDS);

   always_ff @(posedge clock) begin
      if (reset) begin
         candle_seconds_ff  <= ohlc_pkg::CANDLE_SECONDS_RESET;
         valid_epoch_min_ff <= ohlc_pkg::VALID_EPOCH_MIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ohlc_pkg::CSR_CANDLE_SECONDS:
               candle_seconds_ff <= csr_wdata[ohlc_pkg::PERIOD_W-1:0];
            ohlc_pkg::CSR_VALID_EPOCH_MIN:
               valid_epoch_min_ff <= csr_wdata[ohlc_pkg::EPOCH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: IDLE -> DIV -> UPDATE -> FINISH -> IDLE
   // ---------------------------------------------------------------------
   ohlc_pkg::state_type      state_ff;
   ohlc_pkg::state_type      state_in;
   logic                     div_start;
   logic                     update_en;
   logic                     finish_en;
   ohlc_pkg::div_status_type div_status;
   logic                     rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ohlc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      update_en = 1'b0;
      finish_en = 1'b0;
      unique case (state_ff)
         ohlc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               div_start = 1'b1;
               state_in  = ohlc_pkg::ST_DIV;
            end
         end
         ohlc_pkg::ST_DIV: begin
            // Divider raises busy at the accepting edge; leave when it drops
            if (!div_status.busy) begin
               state_in = ohlc_pkg::ST_UPDATE;
            end
         end
         ohlc_pkg::ST_UPDATE: begin
            // Hold until the output register is free or is emptied at this edge
            if (!rsp_valid_ff || rsp_ready) begin
               update_en = 1'b1;
               state_in  = ohlc_pkg::ST_FINISH;
            end
         end
         ohlc_pkg::ST_FINISH: begin
            finish_en = 1'b1;
            state_in  = ohlc_pkg::ST_IDLE;
         end
         default: state_in = ohlc_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Request capture and bucket division
   // ---------------------------------------------------------------------
   logic [ohlc_pkg::EPOCH_W-1:0]    now_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    price_ff;
   logic                            price_valid_ff;
   logic                            time_ok_ff;
   logic [ohlc_pkg::PERIOD_W-1:0]   period_used;

   // A zero period behaves as one second
   assign period_used = (candle_seconds_ff == '0) ? ohlc_pkg::PERIOD_W'(1) : candle_seconds_ff;

   always_ff @(posedge clock) begin
      if (div_start) begin
         now_ff         <= req_now_epoch;
         price_ff       <= req_price;
         price_valid_ff <= req_price_valid;
         time_ok_ff     <= (req_now_epoch >= valid_epoch_min_ff);
      end
   end

   ohlc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_now_epoch),
      .divisor  (period_used),
      .status   (div_status)
   );

   // ---------------------------------------------------------------------
   // Candle state
   // ---------------------------------------------------------------------
   logic [ohlc_pkg::EPOCH_W-1:0]    bucket;
   logic [ohlc_pkg::EPOCH_W-1:0]    bucket_open;
   logic                            tick_ok;

   logic                            forming_valid_ff;
   logic [ohlc_pkg::EPOCH_W-1:0]    forming_start_ff;
   logic [ohlc_pkg::EPOCH_W-1:0]    forming_bucket_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    forming_open_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    forming_high_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    forming_low_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    forming_last_ff;
   logic                            last_closed_valid_ff;
   logic [ohlc_pkg::EPOCH_W-1:0]    last_closed_index_ff;
   logic                            later_bucket;
   logic                            advance_closed;

   assign bucket      = div_status.quotient;
   // bucket * period equals the epoch less the remainder
   assign bucket_open = now_ff - {{(ohlc_pkg::EPOCH_W-ohlc_pkg::PERIOD_W){1'b0}},
                                  div_status.remainder};
   assign tick_ok     = price_valid_ff && time_ok_ff;
   // The period is fixed while a candle forms, so bucket order matches start order
   assign later_bucket   = bucket > forming_bucket_ff;
   assign advance_closed = !last_closed_valid_ff || (forming_bucket_ff > last_closed_index_ff);

   // Valid bits: clear on reset and on a period write
   always_ff @(posedge clock) begin
      if (reset) begin
         forming_valid_ff     <= 1'b0;
         last_closed_valid_ff <= 1'b0;
      end else if (clear_candles) begin
         forming_valid_ff     <= 1'b0;
         last_closed_valid_ff <= 1'b0;
      end else if (update_en && tick_ok) begin
         forming_valid_ff <= 1'b1;
         if (forming_valid_ff && later_bucket) begin
            last_closed_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update_en && tick_ok) begin
         if (!forming_valid_ff || later_bucket) begin
            // Open a fresh candle
            forming_start_ff  <= bucket_open;
            forming_bucket_ff <= bucket;
            forming_open_ff   <= price_ff;
            forming_high_ff   <= price_ff;
            forming_low_ff    <= price_ff;
            forming_last_ff   <= price_ff;
            if (forming_valid_ff && advance_closed) begin
               last_closed_index_ff <= forming_bucket_ff;
            end
         end else begin
            // Same or earlier bucket: extend the forming candle
            if (price_ff > forming_high_ff) begin
               forming_high_ff <= price_ff;
            end
            if (price_ff < forming_low_ff) begin
               forming_low_ff <= price_ff;
            end
            forming_last_ff <= price_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic                            rsp_tick_accepted_ff;
   logic                            rsp_closed_valid_ff;
   logic [ohlc_pkg::EPOCH_W-1:0]    rsp_closed_start_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_open_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_high_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_low_ff;
   logic [ohlc_pkg::PRICE_W-1:0]    rsp_closed_last_ff;
   logic                            rsp_gap_flag_ff;
   logic [ohlc_pkg::GAP_W-1:0]      rsp_gap_count_ff;

   logic [ohlc_pkg::EPOCH_W-1:0]    gap_diff;
   logic                            gap_hit;

   // Gap is measured against the last closed bucket after this request's update
   assign gap_diff = bucket - last_closed_index_ff;
   assign gap_hit  = time_ok_ff && last_closed_valid_ff && (bucket > last_closed_index_ff)
                     && (gap_diff > ohlc_pkg::EPOCH_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update_en) begin
         rsp_tick_accepted_ff <= tick_ok;
         if (tick_ok && forming_valid_ff && later_bucket) begin
            rsp_closed_valid_ff <= 1'b1;
            rsp_closed_start_ff <= forming_start_ff;
            rsp_closed_open_ff  <= forming_open_ff;
            rsp_closed_high_ff  <= forming_high_ff;
            rsp_closed_low_ff   <= forming_low_ff;
            rsp_closed_last_ff  <= forming_last_ff;
         end else begin
            rsp_closed_valid_ff <= 1'b0;
            rsp_closed_start_ff <= '0;
            rsp_closed_open_ff  <= '0;
            rsp_closed_high_ff  <= '0;
            rsp_closed_low_ff   <= '0;
            rsp_closed_last_ff  <= '0;
         end
      end
      if (finish_en) begin
         rsp_gap_flag_ff <= gap_hit;
         if (!gap_hit) begin
            rsp_gap_count_ff <= '0;
         end else if (gap_diff[ohlc_pkg::EPOCH_W-1]) begin
            // Saturate a huge gap
            rsp_gap_count_ff <= ohlc_pkg::GAP_MAX;
         end else begin
            rsp_gap_count_ff <= gap_diff[ohlc_pkg::GAP_W-1:0];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tick_accepted = rsp_tick_accepted_ff;
   assign rsp_closed_valid  = rsp_closed_valid_ff;
   assign rsp_closed_start  = rsp_closed_start_ff;
   assign rsp_closed_open   = rsp_closed_open_ff;
   assign rsp_closed_high   = rsp_closed_high_ff;
   assign rsp_closed_low    = rsp_closed_low_ff;
   assign rsp_closed_last   = rsp_closed_last_ff;
   assign rsp_gap_flag      = rsp_gap_flag_ff;
   assign rsp_gap_count     = rsp_gap_count_ff;

`ifndef SYNTHESIS
   // A closed candle is only reported for an accepted tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closed_valid |-> rsp_tick_accepted)
      else $error("closed candle reported for a dropped tick");

   // A flagged gap spans at least two buckets; an unflagged one reads zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gap_flag ? (rsp_gap_count > ohlc_pkg::GAP_W'(1))
                                  : (rsp_gap_count == '0)))
      else $error("gap count disagrees with gap flag");

   // Low never exceeds high in a reported candle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closed_valid |-> rsp_closed_low <= rsp_closed_high)
      else $error("closed candle low above high");

   // The divider is never busy while the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ohlc_pkg::ST_IDLE |-> !div_status.busy)
      else $error("divider busy while sequencer idle");

   // The forming candle is dropped only by a period write
   assert property (@(posedge clock) disable iff (reset)
      $fell(forming_valid_ff) |-> $past(clear_candles))
      else $error("forming candle lost without a period write");
`endif

endmodule
